/* hw/rtl/ordered_array_list_engine_core_assert.svh */
// assertion macros for the ordered array list engine
// used by the top level only
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define OAL_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication
`define OAL_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

/* hw/rtl/oal_pkg.sv */
// shared types and constants for the ordered array list engine
// no dependencies
`default_nettype none
package oal_pkg;
  localparam int unsigned CapacityDefault  = 16;
  localparam int unsigned DataWidthDefault = 32;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_PREPEND  = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_INS_AFT  = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_DELETE   = 3'd5,
    CMD_POP      = 3'd6,
    CMD_DEQUEUE  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [31:0] key;
    logic [4:0]  position;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_out;
    logic [3:0]  found_index;
    logic [4:0]  entry_count;
  } res_item_t;
endpackage
`default_nettype wire

/* hw/rtl/oal_stream_if.sv */
// valid/ready channel carrying one payload beat
// depends on nothing
`default_nettype none
interface oal_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/oal_front.sv */
// front part: takes command beats into a two-entry queue
// depends on oal_pkg
`default_nettype none
module oal_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  oal_pkg::cmd_item_t       in_item,
  output logic                     q_valid,
  input  wire                      q_take,
  output oal_pkg::cmd_item_t       q_item
);
  import oal_pkg::*;

  cmd_item_t slot [2];
  logic      rd_ptr, wr_ptr;
  logic [1:0] used;
  logic      push, pop;

  assign in_ready = (used != 2'd2);
  assign q_valid  = (used != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/oal_back.sv */
// back part: cell row that matches and shifts; no new command is taken while one is in work or its result waits
// depends on oal_pkg
`default_nettype none
module oal_back #(
  parameter int unsigned CAPACITY   = oal_pkg::CapacityDefault,
  parameter int unsigned DATA_WIDTH = oal_pkg::DataWidthDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_take,
  input  oal_pkg::cmd_item_t  q_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output oal_pkg::res_item_t  out_item
);
  import oal_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CW-1:0]         fill_count;

  // stage registers
  logic                  busy;
  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] val, key;
  logic [4:0]            pos;
  logic [CAPACITY-1:0]   hit;

  // first-match search over the registered hit row
  logic          any_hit;
  logic [IW-1:0] at;
  always_comb begin
    any_hit = 1'b0;
    at      = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        at      = IW'(i);
      end
    end
  end

  assign q_take = q_valid && !busy && (!out_valid || out_ready);

  // compare stage: each cell tests its word
  always_ff @(posedge clk) begin
    if (q_take) begin
      cmd <= cmd_t'(q_item.command);
      val <= q_item.value[DATA_WIDTH-1:0];
      key <= q_item.key[DATA_WIDTH-1:0];
      pos <= q_item.position;
      for (int i = 0; i < CAPACITY; i++) begin
        hit[i] <= (CW'(i) < fill_count) &&
                  (entries[i] == ((q_item.command == CMD_INS_AFT) ?
                   q_item.key[DATA_WIDTH-1:0] : q_item.value[DATA_WIDTH-1:0]));
      end
    end
  end

  // execute decision
  logic          full, do_ins, do_rem;
  logic [CW-1:0] ins_at, rem_at;
  logic [2:0]    st;
  logic [DATA_WIDTH-1:0] rdata;
  logic          has_data;
  always_comb begin
    full     = (fill_count == CW'(CAPACITY));
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    ins_at   = '0;
    rem_at   = '0;
    st       = ST_OK;
    has_data = 1'b0;
    rdata    = entries[0];
    case (cmd)
      CMD_APPEND: begin
        if (full) st = ST_FULL;
        else begin do_ins = 1'b1; ins_at = fill_count; end
      end
      CMD_PREPEND: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_INS_AT: begin
        if ({{(CW > 5 ? CW - 5 : 0){1'b0}}, pos} > (CW > 5 ? CW : 5)'(fill_count))
          st = ST_BAD_POS;
        else if (full) st = ST_FULL;
        else begin do_ins = 1'b1; ins_at = CW'(pos); end
      end
      CMD_INS_AFT: begin
        if (!any_hit) st = ST_NOT_FOUND;
        else if (full) st = ST_FULL;
        else begin do_ins = 1'b1; ins_at = CW'(at) + CW'(1); end
      end
      CMD_FIND: begin
        if (!any_hit) st = ST_NOT_FOUND;
      end
      CMD_DELETE: begin
        if (!any_hit) st = ST_NOT_FOUND;
        else begin do_rem = 1'b1; rem_at = CW'(at); end
      end
      CMD_POP: begin
        if (fill_count == '0) st = ST_EMPTY;
        else begin
          has_data = 1'b1;
          rdata    = entries[IW'(fill_count - CW'(1))];
          rem_at   = fill_count - CW'(1);
          do_rem   = 1'b1;
        end
      end
      default: begin
        if (fill_count == '0) st = ST_EMPTY;
        else begin has_data = 1'b1; do_rem = 1'b1; end
      end
    endcase
  end

  // cell row update: each cell takes the new value, its own, left or right neighbour
  always_ff @(posedge clk) begin
    if (busy) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          if (CW'(i) == ins_at) entries[i] <= val;
          else if (CW'(i) > ins_at && i > 0) entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end else if (do_rem) begin
          if (CW'(i) >= rem_at && i < CAPACITY - 1)
            entries[i] <= entries[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // result register and control
  logic [CW-1:0] cnt_next;
  assign cnt_next = do_ins ? fill_count + CW'(1) :
                    do_rem ? fill_count - CW'(1) : fill_count;

  always_ff @(posedge clk) begin
    if (busy) begin
      out_item.status      <= st;
      out_item.data_out    <= has_data ? 32'($signed(rdata)) : '0;
      out_item.found_index <= (cmd == CMD_FIND && any_hit) ? 4'(at) : 4'd0;
      out_item.entry_count <= 5'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      fill_count <= '0;
    end else begin
      if (busy) begin
        fill_count <= cnt_next;
        out_valid  <= 1'b1;
        busy       <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_take) busy <= 1'b1;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/ordered_array_list_engine_core.sv */
// Ordered list engine holding up to CAPACITY signed words. Each command beat
// enters a two-entry queue; the back part takes one command, registers the
// match row of all cells in its compare step and shifts the cells and forms the
// result in its execute step; no new command is taken while one is in work or
// its result waits. One result beat per command. No clearing pass.
// depends on oal_pkg, oal_stream_if, oal_front, oal_back and the assert header
`default_nettype none
`include "ordered_array_list_engine_core_assert.svh"
module ordered_array_list_engine_core #(
  parameter int unsigned CAPACITY   = oal_pkg::CapacityDefault,
  parameter int unsigned DATA_WIDTH = oal_pkg::DataWidthDefault
) (
  input wire clk,
  input wire rst,
  oal_stream_if.sink   cmd_in,
  oal_stream_if.source res_out
);
  import oal_pkg::*;

  logic      q_valid, q_take;
  cmd_item_t q_item;
  res_item_t r_item;

  oal_front u_front (
    .clk, .rst,
    .in_valid (cmd_in.valid),
    .in_ready (cmd_in.ready),
    .in_item  (cmd_in.payload),
    .q_valid, .q_take, .q_item
  );

  oal_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst,
    .q_valid, .q_take, .q_item,
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_item  (r_item)
  );
  assign res_out.payload = r_item;

  `OAL_ASSERT_IMPL(a_count_range, clk, rst, res_out.valid, r_item.entry_count <= 5'(CAPACITY))
  `OAL_ASSERT_NEXT(a_hold_result, clk, rst, res_out.valid && !res_out.ready, res_out.valid)
  `OAL_ASSERT_IMPL(a_data_on_remove, clk, rst, res_out.valid && r_item.status != ST_OK, r_item.data_out == '0)
endmodule
`default_nettype wire

/* tb/ordered_array_list_engine_core_tb.sv */
// testbench for the ordered array list engine: drives command beats, predicts
// each result with a software list and compares field by field
// depends on oal_pkg, oal_stream_if and ordered_array_list_engine_core
`default_nettype none
module ordered_array_list_engine_core_tb;
  import oal_pkg::*;

  localparam int unsigned Cap = 16;
  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oal_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
  oal_stream_if #(.payload_t(res_item_t)) res_ch ();

  ordered_array_list_engine_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_ch.sink),
    .res_out (res_ch.source)
  );

  always #5 clk = ~clk;

  // software copy of the list
  logic [31:0] list_words[$];
  res_item_t   expected_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          steady_phase = 1'b0;

  // expected result of one command, updating the list copy
  function automatic res_item_t apply_command(cmd_item_t c);
    res_item_t r;
    int hit;
    int n;
    r = '0;
    n = list_words.size();
    hit = -1;
    if (c.command == CMD_INS_AFT) begin
      foreach (list_words[i]) if (hit < 0 && list_words[i] == c.key) hit = i;
    end else begin
      foreach (list_words[i]) if (hit < 0 && list_words[i] == c.value) hit = i;
    end
    r.status = ST_OK;
    case (cmd_t'(c.command))
      CMD_APPEND:
        if (n >= Cap) r.status = ST_FULL; else list_words.push_back(c.value);
      CMD_PREPEND:
        if (n >= Cap) r.status = ST_FULL; else list_words.push_front(c.value);
      CMD_INS_AT:
        if (c.position > n) r.status = ST_BAD_POS;
        else if (n >= Cap) r.status = ST_FULL;
        else list_words.insert(c.position, c.value);
      CMD_INS_AFT:
        if (hit < 0) r.status = ST_NOT_FOUND;
        else if (n >= Cap) r.status = ST_FULL;
        else list_words.insert(hit + 1, c.value);
      CMD_FIND:
        if (hit < 0) r.status = ST_NOT_FOUND; else r.found_index = hit[3:0];
      CMD_DELETE:
        if (hit < 0) r.status = ST_NOT_FOUND; else list_words.delete(hit);
      CMD_POP:
        if (n == 0) r.status = ST_EMPTY; else r.data_out = list_words.pop_back();
      default:
        if (n == 0) r.status = ST_EMPTY; else r.data_out = list_words.pop_front();
    endcase
    r.entry_count = 5'(list_words.size());
    return r;
  endfunction

  function automatic bit idle_now();
    return !steady_phase && ($urandom_range(99) < 19);
  endfunction

  // send one command beat and record its prediction
  task automatic send_command(cmd_t op, logic [31:0] val, logic [31:0] k,
                              logic [4:0] pos);
    cmd_item_t c;
    c.command = op;
    c.value = val;
    c.key = k;
    c.position = pos;
    while (idle_now()) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_results.push_back(apply_command(c));
  endtask

  // result side: random stalls and comparison
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat");
          fail_count++;
        end else begin
          res_item_t e;
          e = expected_results.pop_front();
          if (res_ch.payload.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, res_ch.payload.status);
            fail_count++;
          end
          if (res_ch.payload.data_out !== e.data_out) begin
            $error("data_out expected %h actual %h", e.data_out,
                   res_ch.payload.data_out);
            fail_count++;
          end
          if (res_ch.payload.found_index !== e.found_index) begin
            $error("found_index expected %0d actual %0d", e.found_index,
                   res_ch.payload.found_index);
            fail_count++;
          end
          if (res_ch.payload.entry_count !== e.entry_count) begin
            $error("entry_count expected %0d actual %0d", e.entry_count,
                   res_ch.payload.entry_count);
            fail_count++;
          end
        end
      end
      res_ch.ready <= !idle_now();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    // small pool gives frequent matches, sometimes an extreme or wide word
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(7) - 3;
    endcase
  endfunction

  task automatic test_extremes();
    send_command(CMD_POP, 0, 0, 0);
    send_command(CMD_DEQUEUE, 0, 0, 0);
    send_command(CMD_FIND, 0, 0, 0);
    send_command(CMD_DELETE, 0, 0, 0);
    send_command(CMD_INS_AFT, 1, 1, 0);
    send_command(CMD_INS_AT, 5, 0, 5'd1);
    send_command(CMD_APPEND, 32'h8000_0000, 0, 0);
    send_command(CMD_PREPEND, 32'h7fff_ffff, 0, 0);
    send_command(CMD_INS_AT, 32'hffff_ffff, 0, 5'd2);
    send_command(CMD_INS_AFT, 32'h1234_5678, 32'h7fff_ffff, 0);
    send_command(CMD_FIND, 32'hffff_ffff, 0, 0);
    send_command(CMD_DELETE, 32'h1234_5678, 0, 0);
    send_command(CMD_POP, 0, 0, 0);
    send_command(CMD_DEQUEUE, 0, 0, 0);
    send_command(CMD_INS_AT, 0, 0, 5'd31);
  endtask

  task automatic test_full_list();
    while (list_words.size() < Cap)
      send_command(CMD_APPEND, 32'(list_words.size()), 0, 0);
    send_command(CMD_APPEND, 1, 0, 0);
    send_command(CMD_PREPEND, 1, 0, 0);
    send_command(CMD_INS_AT, 1, 0, 5'd16);
    send_command(CMD_INS_AT, 1, 0, 5'd17);
    send_command(CMD_INS_AFT, 1, 32'd3, 0);
    send_command(CMD_FIND, 32'd15, 0, 0);
  endtask

  task automatic test_random_commands(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      logic [4:0] pos;
      logic [31:0] k;
      steady_phase = (i >= count / 2) && (i < count / 2 + 150);
      pos = ($urandom_range(9) == 0) ? 5'($urandom())
                                     : 5'($urandom_range(list_words.size()));
      k = (list_words.size() > 0 && $urandom_range(3) != 0)
          ? list_words[$urandom_range(list_words.size() - 1)] : pick_word();
      send_command(cmd_t'($urandom_range(7)), pick_word(), k, pos);
    end
    steady_phase = 1'b0;
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_full_list();
    test_random_commands(1250);
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/oal_pkg.sv
hw/rtl/oal_stream_if.sv
hw/rtl/oal_front.sv
hw/rtl/oal_back.sv
hw/rtl/ordered_array_list_engine_core.sv
tb/ordered_array_list_engine_core_tb.sv
